@@ design/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// shared widths, defaults and codes for the sorted range search block
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int unsigned ValueWidth        = 32;
  localparam int unsigned IndexWidth        = 10;
  localparam int unsigned PosWidth          = 11;
  localparam int unsigned CountWidth        = 11;
  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned ApbDataWidth      = 32;
  localparam int unsigned ApbAddrWidth      = 3;

  // item function codes
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // register index taken from paddr[2]
  localparam logic RegEntryCount = 1'b0;

endpackage

`default_nettype wire

@@ design/sorted_range_search.sv @@
// ----------------------------------------------------------------------------
// sorted_range_search
// first and last position of a target in a sorted table by binary search
// ----------------------------------------------------------------------------
// Items enter on start/busy: one is taken at a clock edge with start high and
// busy low. func selects a table write (index, value) or a query (value is
// the target). A write is stored at its accept edge, keeps busy low and
// gives no word. A query raises busy and runs a left-leaning, then a
// right-leaning binary search over the first entry_count entries, at most
// TableDepth; each step is one table read plus one pass through the shared
// compare unit. Each search takes at most floor(log2(entry_count)) + 1 steps
// (11 at 1024 entries); done pulses for one cycle with first_pos/last_pos
// in the cycle busy falls. Results cannot be held off by the receiver.
// entry_count is an APB register at address 0; the user must write it only
// while idle, the block itself does not enforce this.
// Reset clears entry_count and the sequencer; table contents are undefined
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_search #(
  parameter int unsigned TableDepth = srs_pkg::TableDepthDefault
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // item channel
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    func_i,
  input  wire logic [srs_pkg::IndexWidth-1:0]          index_i,
  input  wire logic signed [srs_pkg::ValueWidth-1:0]   value_i,
  // result channel
  output logic                                         done_o,
  output logic signed [srs_pkg::PosWidth-1:0]          first_pos_o,
  output logic signed [srs_pkg::PosWidth-1:0]          last_pos_o,
  // configuration port
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [srs_pkg::ApbAddrWidth-1:0]        paddr,
  input  wire logic [srs_pkg::ApbDataWidth-1:0]        pwdata,
  output logic      [srs_pkg::ApbDataWidth-1:0]        prdata,
  output logic                                         pready
);

  localparam int unsigned AddrWidth = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NumWidth  = $clog2(TableDepth + 1);
  localparam int unsigned PtrWidth  = NumWidth + 1;

  typedef enum logic [1:0] {
    StIdle,
    StAddr,
    StCmp
  } state_e;

  // configuration
  logic [srs_pkg::CountWidth-1:0] count_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == srs_pkg::RegEntryCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_wr) begin
      count_q <= pwdata[srs_pkg::CountWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == srs_pkg::RegEntryCount)
                  ? srs_pkg::ApbDataWidth'(count_q) : '0;

  // sequencer state
  state_e                               state_q;
  logic                                 lean_left_q;
  logic                                 done_q;
  logic signed [PtrWidth-1:0]           lo_q;
  logic signed [PtrWidth-1:0]           hi_q;
  logic signed [PtrWidth-1:0]           found_q;
  logic signed [PtrWidth-1:0]           first_q;
  logic        [AddrWidth-1:0]          mid_q;
  logic signed [srs_pkg::ValueWidth-1:0] target_q;
  logic signed [srs_pkg::PosWidth-1:0]  first_pos_q;
  logic signed [srs_pkg::PosWidth-1:0]  last_pos_q;

  logic                                 accept;
  logic                                 tbl_we;
  logic [NumWidth-1:0]                  num_w;
  logic signed [PtrWidth-1:0]           hi_init;
  logic [PtrWidth:0]                    sum_w;
  logic [AddrWidth-1:0]                 mid_w;
  logic signed [PtrWidth-1:0]           mid_ext;
  logic [srs_pkg::ValueWidth-1:0]       rdata;
  logic signed [PtrWidth-1:0]           step_lo;
  logic signed [PtrWidth-1:0]           step_hi;
  logic signed [PtrWidth-1:0]           step_found;
  logic signed [31:0]                   first_ext;
  logic signed [31:0]                   found_ext;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign tbl_we = accept && (func_i == srs_pkg::FuncWrite)
                  && (32'(index_i) < 32'(TableDepth));

  assign num_w   = (32'(count_q) > 32'(TableDepth)) ? NumWidth'(TableDepth)
                                                    : NumWidth'(count_q);
  assign hi_init = $signed({1'b0, num_w}) - PtrWidth'(1);

  // midpoint, used only while lo <= hi so both are non-negative
  assign sum_w   = (PtrWidth + 1)'($unsigned(lo_q)) + (PtrWidth + 1)'($unsigned(hi_q));
  assign mid_w   = sum_w[AddrWidth:1];
  assign mid_ext = $signed(PtrWidth'(mid_q));

  assign first_ext = 32'(first_q);
  assign found_ext = 32'(found_q);

  srs_ram #(
    .Width (srs_pkg::ValueWidth),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AddrWidth'(index_i)),
    .wdata_i (value_i),
    .raddr_i (mid_w),
    .rdata_o (rdata)
  );

  srs_step #(
    .PtrWidth (PtrWidth)
  ) u_step (
    .lo_i        (lo_q),
    .hi_i        (hi_q),
    .found_i     (found_q),
    .mid_i       (mid_ext),
    .entry_i     ($signed(rdata)),
    .target_i    (target_q),
    .lean_left_i (lean_left_q),
    .lo_o        (step_lo),
    .hi_o        (step_hi),
    .found_o     (step_found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lean_left_q <= 1'b1;
      done_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      found_q     <= '1;
      first_q     <= '1;
      mid_q       <= '0;
      target_q    <= '0;
      first_pos_q <= '0;
      last_pos_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && (func_i == srs_pkg::FuncQuery)) begin
            target_q    <= value_i;
            lo_q        <= '0;
            hi_q        <= hi_init;
            found_q     <= '1;
            lean_left_q <= 1'b1;
            state_q     <= StAddr;
          end
        end
        StAddr: begin
          if (lo_q <= hi_q) begin
            mid_q   <= mid_w;
            state_q <= StCmp;
          end else if (lean_left_q) begin
            first_q     <= found_q;
            lo_q        <= '0;
            hi_q        <= hi_init;
            found_q     <= '1;
            lean_left_q <= 1'b0;
          end else begin
            first_pos_q <= first_ext[srs_pkg::PosWidth-1:0];
            last_pos_q  <= found_ext[srs_pkg::PosWidth-1:0];
            done_q      <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StCmp: begin
          lo_q    <= step_lo;
          hi_q    <= step_hi;
          found_q <= step_found;
          state_q <= StAddr;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign first_pos_o = first_pos_q;
  assign last_pos_o  = last_pos_q;

  // a result word lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // a query ends only with its result word
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("query finished without a result");

  // the probed entry lies inside the live search window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> (mid_ext >= lo_q) && (mid_ext <= hi_q))
    else $error("probe outside search window");

  // a found position lies inside the searched entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && (found_q != '1)) |->
      (found_q >= 0) && (found_q < $signed({1'b0, num_w})))
    else $error("found position outside table");

endmodule

`default_nettype wire

@@ design/srs_ram.sv @@
// ----------------------------------------------------------------------------
// srs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/srs_step.sv @@
// ----------------------------------------------------------------------------
// srs_step
// shared compare unit: one binary search step for either lean direction
// ----------------------------------------------------------------------------
`default_nettype none

module srs_step #(
  parameter int unsigned PtrWidth = 12
) (
  input  wire logic signed [PtrWidth-1:0]             lo_i,
  input  wire logic signed [PtrWidth-1:0]             hi_i,
  input  wire logic signed [PtrWidth-1:0]             found_i,
  input  wire logic signed [PtrWidth-1:0]             mid_i,
  input  wire logic signed [srs_pkg::ValueWidth-1:0] entry_i,
  input  wire logic signed [srs_pkg::ValueWidth-1:0] target_i,
  input  wire logic                                   lean_left_i,
  output logic signed      [PtrWidth-1:0]             lo_o,
  output logic signed      [PtrWidth-1:0]             hi_o,
  output logic signed      [PtrWidth-1:0]             found_o
);

  logic signed [PtrWidth-1:0] mid_dec;
  logic signed [PtrWidth-1:0] mid_inc;

  assign mid_dec = mid_i - PtrWidth'(1);
  assign mid_inc = mid_i + PtrWidth'(1);

  always_comb begin
    lo_o    = lo_i;
    hi_o    = hi_i;
    found_o = found_i;
    if (entry_i > target_i) begin
      hi_o = mid_dec;
    end else if (entry_i < target_i) begin
      lo_o = mid_inc;
    end else begin
      found_o = mid_i;
      if (lean_left_i) begin
        hi_o = mid_dec;
      end else begin
        lo_o = mid_inc;
      end
    end
  end

endmodule

`default_nettype wire
